// File: design/vcm_pkg.sv
`default_nettype none

package vcm_pkg;

  // Field widths fixed by the interface.
  localparam int VCM_VEL_WIDTH = 16;
  localparam int VCM_AGE_WIDTH = 17;
  localparam int CFG_W         = 16;
  localparam int CFG_IDX_W     = 3;

  // Operation codes of an input item.
  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_PUBLISH = 3'd1,
    OP_COMMAND = 3'd2,
    OP_MODE    = 3'd3,
    OP_TRIGGER = 3'd4,
    OP_STOP    = 3'd5
  } vcm_op_e;

  // Mode codes.
  typedef enum logic [2:0] {
    MODE_MANUAL = 3'd0,
    MODE_AUTO   = 3'd1,
    MODE_NAV    = 3'd2,
    MODE_STOP   = 3'd3,
    MODE_IDLE   = 3'd4
  } vcm_mode_e;

  // Source indexes.
  localparam logic [1:0] SRC_RECOVERY = 2'd3;

  // Codes reported on chosen_source.
  localparam logic [3:0] CH_RECOVERY       = 4'd0;
  localparam logic [3:0] CH_RECOVERY_STALE = 4'd1;
  localparam logic [3:0] CH_MANUAL         = 4'd2;
  localparam logic [3:0] CH_MANUAL_STALE   = 4'd3;
  localparam logic [3:0] CH_AUTO           = 4'd4;
  localparam logic [3:0] CH_AUTO_STALE     = 4'd5;
  localparam logic [3:0] CH_NAV            = 4'd6;
  localparam logic [3:0] CH_NAV_STALE      = 4'd7;
  localparam logic [3:0] CH_STOP           = 4'd8;
  localparam logic [3:0] CH_IDLE           = 4'd9;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_CMD_TIMEOUT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REC_TIMEOUT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TRIG_TIMEOUT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_WINDOW  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_MODE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OVERRIDE_EN  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LATCH_TRIG   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_GATE_EN = 3'd7;

  // Reset values of the configuration registers.
  localparam logic [CFG_W-1:0] RST_CMD_TIMEOUT  = 16'd300;
  localparam logic [CFG_W-1:0] RST_REC_TIMEOUT  = 16'd500;
  localparam logic [CFG_W-1:0] RST_TRIG_TIMEOUT = 16'd3000;
  localparam logic [CFG_W-1:0] RST_STOP_WINDOW  = 16'd1000;
  localparam vcm_mode_e        RST_DEFAULT_MODE = MODE_MANUAL;

  typedef struct packed {
    logic [CFG_W-1:0] cmd_age_limit;
    logic [CFG_W-1:0] rec_timeout;
    logic [CFG_W-1:0] trig_timeout;
    logic [CFG_W-1:0] stop_window;
    logic             override_en;
    logic             latch_trig;
    logic             stop_gate_en;
  } vcm_cfg_t;

  // Control state seen by the arbiter.
  typedef struct packed {
    logic [3:0] seen;
    logic       trig_active;
    logic       stop_active;
    logic       stop_seen;
    vcm_mode_e  mode;
  } vcm_flags_t;

  // A mode code outside the defined set falls back to manual.
  function automatic vcm_mode_e sane_mode(input logic [2:0] m);
    vcm_mode_e r;
    r = (m <= MODE_IDLE) ? vcm_mode_e'(m) : MODE_MANUAL;
    return r;
  endfunction

endpackage

`default_nettype wire

// File: design/vcm_cfg.sv
`default_nettype none

module vcm_cfg
  import vcm_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 wr_en,
  input  wire logic [CFG_IDX_W-1:0] wr_index,
  input  wire logic [CFG_W-1:0]     wr_data,
  output vcm_cfg_t                  cfg,
  output logic                      mode_load,
  output vcm_mode_e                 mode_load_val
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cmd_age_limit <= RST_CMD_TIMEOUT;
      cfg.rec_timeout   <= RST_REC_TIMEOUT;
      cfg.trig_timeout  <= RST_TRIG_TIMEOUT;
      cfg.stop_window   <= RST_STOP_WINDOW;
      cfg.override_en   <= 1'b1;
      cfg.latch_trig    <= 1'b1;
      cfg.stop_gate_en  <= 1'b0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_CMD_TIMEOUT:  cfg.cmd_age_limit <= wr_data;
        REG_REC_TIMEOUT:  cfg.rec_timeout   <= wr_data;
        REG_TRIG_TIMEOUT: cfg.trig_timeout  <= wr_data;
        REG_STOP_WINDOW:  cfg.stop_window   <= wr_data;
        REG_OVERRIDE_EN:  cfg.override_en   <= wr_data[0];
        REG_LATCH_TRIG:   cfg.latch_trig    <= wr_data[0];
        REG_STOP_GATE_EN: cfg.stop_gate_en  <= wr_data[0];
        default: ;
      endcase
    end
  end

  // The default mode is not kept here: a write goes straight to the active mode.
  assign mode_load     = wr_en && (wr_index == REG_DEFAULT_MODE);
  assign mode_load_val = sane_mode(wr_data[2:0]);

endmodule

`default_nettype wire

// File: design/vcm_state.sv
`default_nettype none

module vcm_state
  import vcm_pkg::*;
#(
  parameter int VEL_WIDTH = VCM_VEL_WIDTH,
  parameter int AGE_WIDTH = VCM_AGE_WIDTH
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        mode_load,
  input  wire vcm_mode_e                   mode_load_val,
  input  wire logic                        item_en,
  input  wire vcm_op_e                     op,
  input  wire logic [1:0]                  src,
  input  wire logic signed [VEL_WIDTH-1:0] vel_x,
  input  wire logic signed [VEL_WIDTH-1:0] vel_y,
  input  wire logic signed [VEL_WIDTH-1:0] turn_rate,
  input  wire logic [2:0]                  mode_req,
  input  wire logic                        flag,
  input  wire logic                        trig_expire,
  input  wire logic [1:0]                  rd_idx,
  output vcm_flags_t                       flags,
  output logic [AGE_WIDTH-1:0]             rd_age,
  output logic [AGE_WIDTH-1:0]             trig_age,
  output logic [AGE_WIDTH-1:0]             stop_age,
  output logic signed [VEL_WIDTH-1:0]      rd_vel_x,
  output logic signed [VEL_WIDTH-1:0]      rd_vel_y,
  output logic signed [VEL_WIDTH-1:0]      rd_turn_rate
);

  localparam logic [AGE_WIDTH-1:0] AGE_SAT = {1'b1, {(AGE_WIDTH-1){1'b0}}};

  logic [AGE_WIDTH-1:0]        src_age [4];
  logic signed [VEL_WIDTH-1:0] mem_vel_x [4];
  logic signed [VEL_WIDTH-1:0] mem_vel_y [4];
  logic signed [VEL_WIDTH-1:0] mem_turn_rate [4];

  // Ages never pass the saturation value, so its top bit marks saturation.
  function automatic logic [AGE_WIDTH-1:0] age_inc(input logic [AGE_WIDTH-1:0] a);
    return a[AGE_WIDTH-1] ? a : a + AGE_WIDTH'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      flags.seen        <= '0;
      flags.trig_active <= 1'b0;
      flags.stop_active <= 1'b0;
      flags.stop_seen   <= 1'b0;
      flags.mode        <= RST_DEFAULT_MODE;
      for (int i = 0; i < 4; i++) begin
        src_age[i] <= AGE_SAT;
      end
      trig_age <= AGE_SAT;
      stop_age <= AGE_SAT;
    end else begin
      if (mode_load) begin
        flags.mode <= mode_load_val;
      end
      if (item_en) begin
        case (op)
          OP_TICK: begin
            for (int i = 0; i < 4; i++) begin
              src_age[i] <= age_inc(src_age[i]);
            end
            trig_age <= age_inc(trig_age);
            stop_age <= age_inc(stop_age);
          end
          OP_COMMAND: begin
            flags.seen[src] <= 1'b1;
            src_age[src]    <= '0;
          end
          OP_MODE: begin
            if (mode_req <= MODE_IDLE) begin
              flags.mode <= vcm_mode_e'(mode_req);
            end
          end
          OP_TRIGGER: begin
            flags.trig_active <= flag;
            trig_age          <= '0;
          end
          OP_STOP: begin
            flags.stop_active <= flag;
            flags.stop_seen   <= 1'b1;
            stop_age          <= '0;
          end
          OP_PUBLISH: begin
            if (trig_expire) begin
              flags.trig_active <= 1'b0;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_en && op == OP_COMMAND) begin
      mem_vel_x[src]     <= vel_x;
      mem_vel_y[src]     <= vel_y;
      mem_turn_rate[src] <= turn_rate;
    end
  end

  assign rd_age       = src_age[rd_idx];
  assign rd_vel_x     = mem_vel_x[rd_idx];
  assign rd_vel_y     = mem_vel_y[rd_idx];
  assign rd_turn_rate = mem_turn_rate[rd_idx];

endmodule

`default_nettype wire

// File: design/vcm_arbiter.sv
`default_nettype none

module vcm_arbiter
  import vcm_pkg::*;
#(
  parameter int VEL_WIDTH = VCM_VEL_WIDTH,
  parameter int AGE_WIDTH = VCM_AGE_WIDTH
) (
  input  wire vcm_cfg_t                    cfg,
  input  wire vcm_flags_t                  flags,
  input  wire logic [AGE_WIDTH-1:0]        rd_age,
  input  wire logic [AGE_WIDTH-1:0]        trig_age,
  input  wire logic [AGE_WIDTH-1:0]        stop_age,
  input  wire logic signed [VEL_WIDTH-1:0] rd_vel_x,
  input  wire logic signed [VEL_WIDTH-1:0] rd_vel_y,
  input  wire logic signed [VEL_WIDTH-1:0] rd_turn_rate,
  output logic [1:0]                       rd_idx,
  output logic                             trig_expire,
  output logic signed [VEL_WIDTH-1:0]      res_vel_x,
  output logic signed [VEL_WIDTH-1:0]      res_vel_y,
  output logic signed [VEL_WIDTH-1:0]      res_turn_rate,
  output logic [3:0]                       res_chosen,
  output logic                             res_forced
);

  localparam int CMP_W = (AGE_WIDTH > CFG_W) ? AGE_WIDTH : CFG_W;

  logic             override_cand;
  logic             use_override;
  logic [CFG_W-1:0] limit;
  logic             fresh;
  logic             pass_cmd;

  always_comb begin
    override_cand = cfg.override_en && flags.trig_active;
    trig_expire   = override_cand && cfg.latch_trig &&
                    (CMP_W'(trig_age) > CMP_W'(cfg.trig_timeout));
    use_override  = override_cand && !trig_expire;

    // Only one source is looked at per item: recovery under override,
    // otherwise the one the mode names.
    rd_idx = use_override ? SRC_RECOVERY : flags.mode[1:0];
    limit  = use_override ? cfg.rec_timeout : cfg.cmd_age_limit;
    fresh  = flags.seen[rd_idx] && (CMP_W'(rd_age) <= CMP_W'(limit));

    pass_cmd = 1'b0;
    if (use_override) begin
      pass_cmd   = fresh;
      res_chosen = fresh ? CH_RECOVERY : CH_RECOVERY_STALE;
    end else begin
      case (flags.mode)
        MODE_MANUAL: begin
          pass_cmd   = fresh;
          res_chosen = fresh ? CH_MANUAL : CH_MANUAL_STALE;
        end
        MODE_AUTO: begin
          pass_cmd   = fresh;
          res_chosen = fresh ? CH_AUTO : CH_AUTO_STALE;
        end
        MODE_NAV: begin
          pass_cmd   = fresh;
          res_chosen = fresh ? CH_NAV : CH_NAV_STALE;
        end
        MODE_STOP: res_chosen = CH_STOP;
        default:   res_chosen = CH_IDLE;
      endcase
    end

    res_forced = cfg.stop_gate_en && flags.stop_seen && flags.stop_active &&
                 (CMP_W'(stop_age) <= CMP_W'(cfg.stop_window));

    if (pass_cmd && !res_forced) begin
      res_vel_x     = rd_vel_x;
      res_vel_y     = rd_vel_y;
      res_turn_rate = rd_turn_rate;
    end else begin
      res_vel_x     = '0;
      res_vel_y     = '0;
      res_turn_rate = '0;
    end
  end

endmodule

`default_nettype wire

// File: design/velocity_command_mux.sv
// Velocity command multiplexer.
// Input channel (in_valid / in_stall): one item per handshake carrying an
// opcode: tick, publish, source command, mode request, recovery trigger or
// safety stop. Only a publish item produces a result; every other item just
// updates the stored commands, ages, mode or flags.
// Output channel (out_valid / out_stall): one result per publish item, with
// the selected velocity, the chosen source code, the stop-forced flag and
// the active mode.
// Configuration port (cfg_valid / cfg_ready, cfg_index, cfg_data): eight
// registers; the user must write them only while no item is in flight, and
// the block itself does not enforce this; cfg_ready is always high.
// An accepted item sits in the input register; one compare-and-select pass
// then loads a publish item's result into the output register once that holds
// no stalled result. Throughput is one item per cycle unless a publish waits.
// Reset: configuration returns to defaults, all ages saturate, no source is
// seen, trigger and stop are cleared and both registers are emptied.
// When out_stall holds a result, the next publish waits in the input register
// and in_stall rises; non-publish items ahead of it still flow through.
`default_nettype none

module velocity_command_mux
  import vcm_pkg::*;
#(
  parameter int VEL_WIDTH = VCM_VEL_WIDTH,
  parameter int AGE_WIDTH = VCM_AGE_WIDTH
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [2:0]                  opcode,
  input  wire logic [1:0]                  source,
  input  wire logic signed [VEL_WIDTH-1:0] vel_x,
  input  wire logic signed [VEL_WIDTH-1:0] vel_y,
  input  wire logic signed [VEL_WIDTH-1:0] turn_rate,
  input  wire logic [2:0]                  mode_request,
  input  wire logic                        flag,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic signed [VEL_WIDTH-1:0]      out_vel_x,
  output logic signed [VEL_WIDTH-1:0]      out_vel_y,
  output logic signed [VEL_WIDTH-1:0]      out_turn_rate,
  output logic [3:0]                       chosen_source,
  output logic                             stop_forced,
  output logic [2:0]                       current_mode,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [CFG_W-1:0]            cfg_data
);

  vcm_cfg_t   cfg;
  vcm_flags_t flags;
  logic       mode_load;
  vcm_mode_e  mode_load_val;

  logic                        s1_valid;
  vcm_op_e                     s1_op;
  logic [1:0]                  s1_src;
  logic signed [VEL_WIDTH-1:0] s1_vel_x;
  logic signed [VEL_WIDTH-1:0] s1_vel_y;
  logic signed [VEL_WIDTH-1:0] s1_turn_rate;
  logic [2:0]                  s1_mode_req;
  logic                        s1_flag;

  logic                        in_accept;
  logic                        s1_is_pub;
  logic                        s1_adv;
  logic                        out_load;

  logic [1:0]                  rd_idx;
  logic                        trig_expire;
  logic [AGE_WIDTH-1:0]        rd_age;
  logic [AGE_WIDTH-1:0]        trig_age;
  logic [AGE_WIDTH-1:0]        stop_age;
  logic signed [VEL_WIDTH-1:0] rd_vel_x;
  logic signed [VEL_WIDTH-1:0] rd_vel_y;
  logic signed [VEL_WIDTH-1:0] rd_turn_rate;
  logic signed [VEL_WIDTH-1:0] res_vel_x;
  logic signed [VEL_WIDTH-1:0] res_vel_y;
  logic signed [VEL_WIDTH-1:0] res_turn_rate;
  logic [3:0]                  res_chosen;
  logic                        res_forced;

  assign cfg_ready = 1'b1;

  // A publish needs the output register free; other items never wait.
  assign s1_is_pub = (s1_op == OP_PUBLISH);
  assign s1_adv    = s1_valid && (!s1_is_pub || !out_valid || !out_stall);
  assign out_load  = s1_adv && s1_is_pub;
  assign in_stall  = s1_valid && !s1_adv;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_op        <= vcm_op_e'(opcode);
      s1_src       <= source;
      s1_vel_x     <= vel_x;
      s1_vel_y     <= vel_y;
      s1_turn_rate <= turn_rate;
      s1_mode_req  <= mode_request;
      s1_flag      <= flag;
    end
    if (out_load) begin
      out_vel_x     <= res_vel_x;
      out_vel_y     <= res_vel_y;
      out_turn_rate <= res_turn_rate;
      chosen_source <= res_chosen;
      stop_forced   <= res_forced;
      current_mode  <= flags.mode;
    end
  end

  vcm_cfg u_cfg (
    .clk           (clk),
    .rst           (rst),
    .wr_en         (cfg_valid && cfg_ready),
    .wr_index      (cfg_index),
    .wr_data       (cfg_data),
    .cfg           (cfg),
    .mode_load     (mode_load),
    .mode_load_val (mode_load_val)
  );

  vcm_state #(
    .VEL_WIDTH (VEL_WIDTH),
    .AGE_WIDTH (AGE_WIDTH)
  ) u_state (
    .clk           (clk),
    .rst           (rst),
    .mode_load     (mode_load),
    .mode_load_val (mode_load_val),
    .item_en       (s1_adv),
    .op            (s1_op),
    .src           (s1_src),
    .vel_x         (s1_vel_x),
    .vel_y         (s1_vel_y),
    .turn_rate     (s1_turn_rate),
    .mode_req      (s1_mode_req),
    .flag          (s1_flag),
    .trig_expire   (trig_expire),
    .rd_idx        (rd_idx),
    .flags         (flags),
    .rd_age        (rd_age),
    .trig_age      (trig_age),
    .stop_age      (stop_age),
    .rd_vel_x      (rd_vel_x),
    .rd_vel_y      (rd_vel_y),
    .rd_turn_rate  (rd_turn_rate)
  );

  vcm_arbiter #(
    .VEL_WIDTH (VEL_WIDTH),
    .AGE_WIDTH (AGE_WIDTH)
  ) u_arbiter (
    .cfg           (cfg),
    .flags         (flags),
    .rd_age        (rd_age),
    .trig_age      (trig_age),
    .stop_age      (stop_age),
    .rd_vel_x      (rd_vel_x),
    .rd_vel_y      (rd_vel_y),
    .rd_turn_rate  (rd_turn_rate),
    .rd_idx        (rd_idx),
    .trig_expire   (trig_expire),
    .res_vel_x     (res_vel_x),
    .res_vel_y     (res_vel_y),
    .res_turn_rate (res_turn_rate),
    .res_chosen    (res_chosen),
    .res_forced    (res_forced)
  );

endmodule

`default_nettype wire

// File: design/vcm_checker.sv
`default_nettype none

module vcm_checker
  import vcm_pkg::*;
#(
  parameter int VEL_WIDTH = VCM_VEL_WIDTH
) (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 out_valid,
  input wire logic                 out_stall,
  input wire logic [VEL_WIDTH-1:0] out_vel_x,
  input wire logic [VEL_WIDTH-1:0] out_vel_y,
  input wire logic [VEL_WIDTH-1:0] out_turn_rate,
  input wire logic [3:0]           chosen_source,
  input wire logic                 stop_forced,
  input wire logic [2:0]           current_mode
);

  // A stalled result stays in place.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_vel_x) &&
      $stable(out_vel_y) && $stable(out_turn_rate) && $stable(chosen_source))
    else $error("result changed while stalled");

  // The safety gate always yields a zero command.
  a_forced_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && stop_forced |->
      out_vel_x == '0 && out_vel_y == '0 && out_turn_rate == '0)
    else $error("forced stop with nonzero velocity");

  // Stale sources, stop and idle all give a zero command.
  a_stale_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (chosen_source[0] || chosen_source == CH_STOP) |->
      out_vel_x == '0 && out_vel_y == '0 && out_turn_rate == '0)
    else $error("stale or halted source with nonzero velocity");

  // Source code and mode must stay in the defined ranges.
  a_codes: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> chosen_source <= CH_IDLE && current_mode <= MODE_IDLE)
    else $error("result code out of range");

endmodule

bind velocity_command_mux vcm_checker #(
  .VEL_WIDTH (VEL_WIDTH)
) u_vcm_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_vel_x     (out_vel_x),
  .out_vel_y     (out_vel_y),
  .out_turn_rate (out_turn_rate),
  .chosen_source (chosen_source),
  .stop_forced   (stop_forced),
  .current_mode  (current_mode)
);

`default_nettype wire
